/* rtl/core/jsc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and literal tables for the JSON syntax checker.
package jsc_pkg;

  typedef enum logic [4:0] {
    MODE_VALUE,
    MODE_ARR_FIRST,
    MODE_KEY_FIRST,
    MODE_KEY,
    MODE_COLON,
    MODE_STR,
    MODE_ESC,
    MODE_HEX,
    MODE_LIT,
    MODE_NUM_SIGN,
    MODE_NUM_ZERO,
    MODE_NUM_INT,
    MODE_NUM_DOT,
    MODE_NUM_FRAC,
    MODE_NUM_E,
    MODE_NUM_ESIGN,
    MODE_NUM_EXP,
    MODE_AFTER_TOP,
    MODE_AFTER_ARR,
    MODE_AFTER_OBJ
  } mode_t;

  localparam logic [4:0] ERR_NONE       = 5'd0;
  localparam logic [4:0] ERR_END        = 5'd1;
  localparam logic [4:0] ERR_CHAR       = 5'd2;
  localparam logic [4:0] ERR_LITERAL    = 5'd3;
  localparam logic [4:0] ERR_NUMBER     = 5'd4;
  localparam logic [4:0] ERR_STRING     = 5'd5;
  localparam logic [4:0] ERR_ESC_END    = 5'd6;
  localparam logic [4:0] ERR_ESCAPE     = 5'd7;
  localparam logic [4:0] ERR_HEX        = 5'd8;
  localparam logic [4:0] ERR_KEY        = 5'd9;
  localparam logic [4:0] ERR_COLON      = 5'd10;
  localparam logic [4:0] ERR_ARR_SEP    = 5'd11;
  localparam logic [4:0] ERR_OBJ_SEP    = 5'd12;
  localparam logic [4:0] ERR_OPEN_ARR   = 5'd13;
  localparam logic [4:0] ERR_OPEN_OBJ   = 5'd14;
  localparam logic [4:0] ERR_DEPTH      = 5'd15;
  localparam logic [4:0] ERR_TRAILING   = 5'd16;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam logic [7:0] NEST_LIMIT_RST = 8'd128;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] hex_cnt;
    logic [2:0] lit_idx;
    logic [1:0] lit_kind;
    logic       is_key;
    logic [4:0] err;
  } parse_state_t;

  localparam parse_state_t PARSE_RST = '{
    mode:     MODE_VALUE,
    hex_cnt:  3'd0,
    lit_idx:  3'd0,
    lit_kind: 2'd0,
    is_key:   1'b0,
    err:      ERR_NONE
  };

  typedef struct packed {
    logic push;
    logic pop;
    logic push_bit;  // 1 = object, 0 = array
  } stack_op_t;

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    case (kind)
      LIT_TRUE:  return 3'd4;
      LIT_FALSE: return 3'd5;
      LIT_NULL:  return 3'd4;
      default:   return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      LIT_TRUE: begin
        case (idx)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (idx)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      LIT_NULL: begin
        case (idx)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/jsc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for document bytes, verdicts and configuration.
interface jsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       last;
  modport source (output valid, output byte_req, output last, input ready);
  modport sink   (input valid, input byte_req, input last, output ready);
endinterface

interface jsc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] error_code;
  logic       done_res;
  logic [7:0] nest_level;
  modport source (output valid, output error_code, output done_res, output nest_level,
                  input ready);
  modport sink   (input valid, input error_code, input done_res, input nest_level,
                  output ready);
endinterface

interface jsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/jsc_grammar.sv */
`timescale 1ns / 1ps
// Combinational grammar step: next parse state, stack operation and verdict for one byte.
module jsc_grammar #(
  parameter int MAX_NEST = 128,
  parameter int DW       = 8
) (
  input  jsc_pkg::parse_state_t state_i,
  input  logic [DW-1:0]         depth_i,
  input  logic                  top_i,
  input  logic                  below_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  logic [7:0]            nest_limit_i,
  output jsc_pkg::parse_state_t state_o,
  output logic [DW-1:0]         depth_o,
  output jsc_pkg::stack_op_t    op_o,
  output logic [4:0]            error_o,
  output logic [7:0]            level_o
);

  localparam int CW = (DW > 8) ? DW : 8;

  typedef struct packed {
    jsc_pkg::parse_state_t st;
    logic [DW-1:0]         depth;
    logic                  top;
    logic                  push;
    logic                  pop;
    logic                  redo;
  } step_t;

  logic [CW-1:0] depth_ext;
  logic          at_limit;

  assign depth_ext = CW'(depth_i);
  assign at_limit  = (depth_ext >= CW'(nest_limit_i)) || (depth_ext >= CW'(MAX_NEST));

  function automatic logic is_ws(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [4:0] keep_err(input logic [4:0] e, input logic [4:0] code);
    return (e == jsc_pkg::ERR_NONE) ? code : e;
  endfunction

  function automatic jsc_pkg::mode_t after_mode(input logic [DW-1:0] d, input logic tp);
    if (d == '0) return jsc_pkg::MODE_AFTER_TOP;
    return tp ? jsc_pkg::MODE_AFTER_OBJ : jsc_pkg::MODE_AFTER_ARR;
  endfunction

  function automatic step_t do_pop(input step_t s, input logic bl);
    step_t r;
    r = s;
    if (s.depth != '0) begin
      r.depth = s.depth - 1'b1;
      r.top   = bl;
      r.pop   = 1'b1;
    end
    r.st.mode = after_mode(r.depth, r.top);
    return r;
  endfunction

  function automatic step_t start_value(input step_t s, input logic [7:0] c,
                                        input logic lim);
    step_t r;
    r = s;
    if (c == "\"") begin
      r.st.is_key = 1'b0;
      r.st.mode   = jsc_pkg::MODE_STR;
    end else if ((c == "{") || (c == "[")) begin
      if (lim) begin
        r.st.err = keep_err(s.st.err, jsc_pkg::ERR_DEPTH);
      end else begin
        r.push    = 1'b1;
        r.top     = (c == "{");
        r.depth   = s.depth + 1'b1;
        r.st.mode = (c == "{") ? jsc_pkg::MODE_KEY_FIRST : jsc_pkg::MODE_ARR_FIRST;
      end
    end else if ((c == "t") || (c == "f") || (c == "n")) begin
      r.st.lit_kind = (c == "t") ? jsc_pkg::LIT_TRUE :
                      (c == "f") ? jsc_pkg::LIT_FALSE : jsc_pkg::LIT_NULL;
      r.st.lit_idx  = 3'd1;
      r.st.mode     = jsc_pkg::MODE_LIT;
    end else if (c == "-") begin
      r.st.mode = jsc_pkg::MODE_NUM_SIGN;
    end else if (c == "0") begin
      r.st.mode = jsc_pkg::MODE_NUM_ZERO;
    end else if (is_dig(c)) begin
      r.st.mode = jsc_pkg::MODE_NUM_INT;
    end else begin
      r.st.err = keep_err(s.st.err, jsc_pkg::ERR_CHAR);
    end
    return r;
  endfunction

  // One pass over the byte; redo is set when the byte closed a number and
  // has to be taken again in the mode that follows a value.
  function automatic step_t consume(input step_t s, input logic [7:0] c,
                                    input logic bl, input logic lim);
    step_t      r;
    logic       is_e;
    logic [2:0] cnt;
    logic [2:0] idx;
    r      = s;
    r.redo = 1'b0;
    is_e   = (c == "e") || (c == "E");
    cnt    = s.st.hex_cnt + 1'b1;
    idx    = s.st.lit_idx + 1'b1;
    unique case (s.st.mode)
      jsc_pkg::MODE_VALUE: begin
        if (!is_ws(c)) r = start_value(r, c, lim);
      end
      jsc_pkg::MODE_ARR_FIRST: begin
        if (c == "]") r = do_pop(r, bl);
        else if (!is_ws(c)) r = start_value(r, c, lim);
      end
      jsc_pkg::MODE_KEY_FIRST, jsc_pkg::MODE_KEY: begin
        if (is_ws(c)) begin
          r = s;
        end else if ((c == "}") && (s.st.mode == jsc_pkg::MODE_KEY_FIRST)) begin
          r = do_pop(r, bl);
        end else if (c == "\"") begin
          r.st.is_key = 1'b1;
          r.st.mode   = jsc_pkg::MODE_STR;
        end else begin
          r.st.err = keep_err(s.st.err, jsc_pkg::ERR_KEY);
        end
      end
      jsc_pkg::MODE_COLON: begin
        if (c == ":") r.st.mode = jsc_pkg::MODE_VALUE;
        else if (!is_ws(c)) r.st.err = keep_err(s.st.err, jsc_pkg::ERR_COLON);
      end
      jsc_pkg::MODE_STR: begin
        if (c == "\"") begin
          r.st.mode = s.st.is_key ? jsc_pkg::MODE_COLON : after_mode(s.depth, s.top);
        end else if (c == "\\") begin
          r.st.mode = jsc_pkg::MODE_ESC;
        end
      end
      jsc_pkg::MODE_ESC: begin
        if (c == "u") begin
          r.st.hex_cnt = 3'd0;
          r.st.mode    = jsc_pkg::MODE_HEX;
        end else if ((c == "\"") || (c == "\\") || (c == "/") || (c == "b") ||
                     (c == "f") || (c == "n") || (c == "r") || (c == "t")) begin
          r.st.mode = jsc_pkg::MODE_STR;
        end else begin
          r.st.err = keep_err(s.st.err, jsc_pkg::ERR_ESCAPE);
        end
      end
      jsc_pkg::MODE_HEX: begin
        if (cnt >= 3'd4) begin
          r.st.hex_cnt = 3'd0;
          r.st.mode    = jsc_pkg::MODE_STR;
        end else begin
          r.st.hex_cnt = cnt;
        end
      end
      jsc_pkg::MODE_LIT: begin
        if ((s.st.lit_kind > jsc_pkg::LIT_NULL) ||
            (s.st.lit_idx >= jsc_pkg::lit_len(s.st.lit_kind)) ||
            (jsc_pkg::lit_char(s.st.lit_kind, s.st.lit_idx) != c)) begin
          r.st.err = keep_err(s.st.err, jsc_pkg::ERR_LITERAL);
        end else if (idx >= jsc_pkg::lit_len(s.st.lit_kind)) begin
          r.st.lit_idx = 3'd0;
          r.st.mode    = after_mode(s.depth, s.top);
        end else begin
          r.st.lit_idx = idx;
        end
      end
      jsc_pkg::MODE_NUM_SIGN: begin
        if (c == "0") r.st.mode = jsc_pkg::MODE_NUM_ZERO;
        else if (is_dig(c)) r.st.mode = jsc_pkg::MODE_NUM_INT;
        else r.st.err = keep_err(s.st.err, jsc_pkg::ERR_NUMBER);
      end
      jsc_pkg::MODE_NUM_ZERO, jsc_pkg::MODE_NUM_INT, jsc_pkg::MODE_NUM_FRAC: begin
        if (is_dig(c) && (s.st.mode != jsc_pkg::MODE_NUM_ZERO)) begin
          r = s;
        end else if ((c == ".") && (s.st.mode != jsc_pkg::MODE_NUM_FRAC)) begin
          r.st.mode = jsc_pkg::MODE_NUM_DOT;
        end else if (is_e) begin
          r.st.mode = jsc_pkg::MODE_NUM_E;
        end else begin
          r.st.mode = after_mode(s.depth, s.top);
          r.redo    = 1'b1;
        end
      end
      jsc_pkg::MODE_NUM_DOT: begin
        if (is_dig(c)) r.st.mode = jsc_pkg::MODE_NUM_FRAC;
        else r.st.err = keep_err(s.st.err, jsc_pkg::ERR_NUMBER);
      end
      jsc_pkg::MODE_NUM_E: begin
        if ((c == "+") || (c == "-")) r.st.mode = jsc_pkg::MODE_NUM_ESIGN;
        else if (is_dig(c)) r.st.mode = jsc_pkg::MODE_NUM_EXP;
        else r.st.err = keep_err(s.st.err, jsc_pkg::ERR_NUMBER);
      end
      jsc_pkg::MODE_NUM_ESIGN: begin
        if (is_dig(c)) r.st.mode = jsc_pkg::MODE_NUM_EXP;
        else r.st.err = keep_err(s.st.err, jsc_pkg::ERR_NUMBER);
      end
      jsc_pkg::MODE_NUM_EXP: begin
        if (!is_dig(c)) begin
          r.st.mode = after_mode(s.depth, s.top);
          r.redo    = 1'b1;
        end
      end
      jsc_pkg::MODE_AFTER_TOP: begin
        if (!is_ws(c)) r.st.err = keep_err(s.st.err, jsc_pkg::ERR_TRAILING);
      end
      jsc_pkg::MODE_AFTER_ARR: begin
        if (c == ",") r.st.mode = jsc_pkg::MODE_VALUE;
        else if (c == "]") r = do_pop(r, bl);
        else if (!is_ws(c)) r.st.err = keep_err(s.st.err, jsc_pkg::ERR_ARR_SEP);
      end
      jsc_pkg::MODE_AFTER_OBJ: begin
        if (c == ",") r.st.mode = jsc_pkg::MODE_KEY;
        else if (c == "}") r = do_pop(r, bl);
        else if (!is_ws(c)) r.st.err = keep_err(s.st.err, jsc_pkg::ERR_OBJ_SEP);
      end
      default: r.st.err = keep_err(s.st.err, jsc_pkg::ERR_CHAR);
    endcase
    return r;
  endfunction

  // Verdict for a document that stops in the given state; an open number
  // that ends in a digit counts as complete.
  function automatic logic [4:0] end_code(input step_t s);
    jsc_pkg::mode_t m;
    logic [4:0]     code;
    m = s.st.mode;
    if ((m == jsc_pkg::MODE_NUM_ZERO) || (m == jsc_pkg::MODE_NUM_INT) ||
        (m == jsc_pkg::MODE_NUM_FRAC) || (m == jsc_pkg::MODE_NUM_EXP)) begin
      m = after_mode(s.depth, s.top);
    end
    unique case (m)
      jsc_pkg::MODE_VALUE, jsc_pkg::MODE_ARR_FIRST:  code = jsc_pkg::ERR_END;
      jsc_pkg::MODE_KEY_FIRST, jsc_pkg::MODE_KEY:    code = jsc_pkg::ERR_KEY;
      jsc_pkg::MODE_COLON:                           code = jsc_pkg::ERR_COLON;
      jsc_pkg::MODE_STR:                             code = jsc_pkg::ERR_STRING;
      jsc_pkg::MODE_ESC:                             code = jsc_pkg::ERR_ESC_END;
      jsc_pkg::MODE_HEX:                             code = jsc_pkg::ERR_HEX;
      jsc_pkg::MODE_LIT:                             code = jsc_pkg::ERR_LITERAL;
      jsc_pkg::MODE_AFTER_TOP:                       code = jsc_pkg::ERR_NONE;
      jsc_pkg::MODE_AFTER_ARR:                       code = jsc_pkg::ERR_OPEN_ARR;
      jsc_pkg::MODE_AFTER_OBJ:                       code = jsc_pkg::ERR_OPEN_OBJ;
      default:                                       code = jsc_pkg::ERR_NUMBER;
    endcase
    return code;
  endfunction

  always_comb begin
    step_t s0;
    step_t s1;
    step_t sf;
    s0.st    = state_i;
    s0.depth = depth_i;
    s0.top   = top_i;
    s0.push  = 1'b0;
    s0.pop   = 1'b0;
    s0.redo  = 1'b0;
    s1       = s0;
    sf       = s0;
    if (state_i.err == jsc_pkg::ERR_NONE) begin
      s1 = consume(s0, byte_i, below_i, at_limit);
      sf = s1;
      if (s1.redo && (s1.st.err == jsc_pkg::ERR_NONE)) begin
        sf = consume(s1, byte_i, below_i, at_limit);
      end
      if (last_i && (sf.st.err == jsc_pkg::ERR_NONE)) begin
        sf.st.err = end_code(sf);
      end
    end
    error_o = sf.st.err;
    level_o = 8'(sf.depth);
    op_o.push     = sf.push;
    op_o.pop      = sf.pop;
    op_o.push_bit = sf.top;
    state_o = last_i ? jsc_pkg::PARSE_RST : sf.st;
    depth_o = last_i ? '0 : sf.depth;
  end

endmodule

/* rtl/core/jsc_stack.sv */
`timescale 1ns / 1ps
// Array/object nesting stack: one-bit memory with a cached top and a prefetched entry below it.
module jsc_stack #(
  parameter int MAX_NEST = 128,
  parameter int DW       = 8
) (
  input  logic               clk,
  input  logic               en,
  input  jsc_pkg::stack_op_t op_i,
  input  logic [DW-1:0]      depth_i,
  input  logic [DW-1:0]      depth_nxt_i,
  output logic               top_o,
  output logic               below_o
);

  localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  logic          mem [MAX_NEST];
  logic          top_r;
  logic          below_r;
  logic [DW-1:0] rd_addr;

  // The entry under the next top is read ahead so a pop has it ready.
  assign rd_addr = depth_nxt_i - DW'(2);

  always_ff @(posedge clk) begin
    if (en && op_i.push) begin
      mem[depth_i[AW-1:0]] <= op_i.push_bit;
    end
    below_r <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (op_i.pop) begin
        top_r <= below_r;
      end else if (op_i.push) begin
        top_r <= op_i.push_bit;
      end
    end
  end

  assign top_o   = top_r;
  assign below_o = below_r;

endmodule

/* rtl/core/json_syntax_checker.sv */
`timescale 1ns / 1ps
// Top level of the streaming JSON syntax checker.
//
//  channel  | dir | payload                              | accepted when
//  in_s     | in  | byte_req[7:0], last                  | valid && ready
//  out_m    | out | error_code[4:0], done_res, nest_level| valid && ready
//  cfg_s    | in  | data[7:0] = nest_limit               | valid && ready
//
// One byte per cycle while out_m is not stalled; its verdict word appears in the
// cycle after it is taken. The verdict comes from the single grammar step and the
// nesting stack memory, whose entry under the top is read ahead.
// Synchronous active-low reset clears the parse state and sets nest_limit to 128.
// A waiting verdict is held in the output register; a new byte is taken in the
// cycle that word leaves, so a stall on out_m stops in_s only while it lasts.
module json_syntax_checker #(
  parameter int MAX_NEST = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  jsc_in_if.sink          in_s,
  jsc_out_if.source       out_m,
  jsc_cfg_if.sink         cfg_s
);

  localparam int DW = $clog2(MAX_NEST + 1);

  jsc_pkg::parse_state_t state_r;
  jsc_pkg::parse_state_t state_nxt;
  jsc_pkg::stack_op_t    op;
  logic [DW-1:0]         depth_r;
  logic [DW-1:0]         depth_step;
  logic [DW-1:0]         depth_nxt;
  logic [7:0]            nest_limit_r;
  logic                  top;
  logic                  below;
  logic                  accept;
  logic [4:0]            error_nxt;
  logic [7:0]            level_nxt;
  logic                  out_valid_r;
  logic [4:0]            error_code_r;
  logic                  done_res_r;
  logic [7:0]            nest_level_r;

  assign in_s.ready  = !out_valid_r || out_m.ready;
  assign accept      = in_s.valid && in_s.ready;
  assign cfg_s.ready = 1'b1;
  assign depth_nxt   = accept ? depth_step : depth_r;

  jsc_grammar #(
    .MAX_NEST (MAX_NEST),
    .DW       (DW)
  ) u_grammar (
    .state_i      (state_r),
    .depth_i      (depth_r),
    .top_i        (top),
    .below_i      (below),
    .byte_i       (in_s.byte_req),
    .last_i       (in_s.last),
    .nest_limit_i (nest_limit_r),
    .state_o      (state_nxt),
    .depth_o      (depth_step),
    .op_o         (op),
    .error_o      (error_nxt),
    .level_o      (level_nxt)
  );

  jsc_stack #(
    .MAX_NEST (MAX_NEST),
    .DW       (DW)
  ) u_stack (
    .clk         (clk),
    .en          (accept),
    .op_i        (op),
    .depth_i     (depth_r),
    .depth_nxt_i (depth_nxt),
    .top_o       (top),
    .below_o     (below)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= jsc_pkg::PARSE_RST;
      depth_r      <= '0;
      nest_limit_r <= jsc_pkg::NEST_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_s.valid) begin
        nest_limit_r <= cfg_s.data;
      end
      if (accept) begin
        state_r     <= state_nxt;
        depth_r     <= depth_step;
        out_valid_r <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      error_code_r <= error_nxt;
      done_res_r   <= in_s.last;
      nest_level_r <= level_nxt;
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.error_code = error_code_r;
  assign out_m.done_res   = done_res_r;
  assign out_m.nest_level = nest_level_r;

endmodule

/* rtl/core/jsc_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the JSON syntax checker and their bind to the top level.
module jsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] error_code,
  input logic       done_res,
  input logic [7:0] nest_level
);

  logic       out_acc;
  logic       prev_open_r;
  logic [4:0] prev_err_r;
  logic [7:0] prev_lvl_r;
  logic [7:0] lvl_diff;

  assign out_acc  = out_valid && out_ready;
  assign lvl_diff = nest_level - prev_lvl_r;

  // Remembers the previous verdict word of the document still in progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_open_r <= 1'b0;
    end else if (out_acc) begin
      prev_open_r <= !done_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_err_r <= error_code;
      prev_lvl_r <= nest_level;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({error_code, done_res, nest_level}))
    else $error("verdict word changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && prev_open_r && (prev_err_r != jsc_pkg::ERR_NONE) |->
      (error_code == prev_err_r) && (nest_level == prev_lvl_r))
    else $error("error code or nesting moved after an error");

  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && prev_open_r && (prev_err_r == jsc_pkg::ERR_NONE) |->
      (lvl_diff == 8'd0) || (lvl_diff == 8'd1) || (lvl_diff == 8'hFF))
    else $error("nesting level moved by more than one in a byte");

endmodule

bind json_syntax_checker jsc_checker u_jsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_s.valid),
  .in_ready   (in_s.ready),
  .out_valid  (out_m.valid),
  .out_ready  (out_m.ready),
  .error_code (out_m.error_code),
  .done_res   (out_m.done_res),
  .nest_level (out_m.nest_level)
);
